>>> sv/icp_pkg.sv
// ----------------------------------------------------------------------------
// icp_pkg
// Shared types and constants of the incircle predicate pipeline.
// ----------------------------------------------------------------------------
package icp_pkg;

    // register stages in the front end (differences, products, sums)
    localparam int ICP_FRONT_STAGES = 3;
    // register stages in the lifted determinant section
    localparam int ICP_LIFT_STAGES  = 3;
    // total stages including the output register
    localparam int ICP_STAGES       = ICP_FRONT_STAGES + ICP_LIFT_STAGES + 1;

    // width of the result word
    localparam int ICP_OUT_W        = 8;

    // per-item status that rides along with the arithmetic
    typedef struct packed {
        logic boundary;
        logic degen;
        logic cw;
    } t_icp_flags;

endpackage

>>> sv/icp_front.sv
// ----------------------------------------------------------------------------
// icp_front
// First three stages: coordinate differences, pairwise products, then the
// orientation determinant, the three lifted norms and the three 2x2 minors.
// ----------------------------------------------------------------------------
module icp_front
    import icp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic [ICP_FRONT_STAGES-1:0]    i_en,
    input  logic                           i_boundary,
    input  logic signed [COORD_BITS-1:0]   i_a_x,
    input  logic signed [COORD_BITS-1:0]   i_a_y,
    input  logic signed [COORD_BITS-1:0]   i_b_x,
    input  logic signed [COORD_BITS-1:0]   i_b_y,
    input  logic signed [COORD_BITS-1:0]   i_c_x,
    input  logic signed [COORD_BITS-1:0]   i_c_y,
    input  logic signed [COORD_BITS-1:0]   i_q_x,
    input  logic signed [COORD_BITS-1:0]   i_q_y,
    output t_icp_flags                     o_flags,
    output logic signed [2*COORD_BITS+2:0] o_norm  [3],
    output logic signed [2*COORD_BITS+2:0] o_cross [3]
);

    localparam int DW  = COORD_BITS + 1;
    localparam int PW1 = 2 * DW;
    localparam int SW  = PW1 + 1;

    // stage 1: differences
    logic signed [DW-1:0]  r_ux, r_uy, r_vx, r_vy;
    logic signed [DW-1:0]  r_dx [3];
    logic signed [DW-1:0]  r_dy [3];
    logic                  r_bnd1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_bnd1 <= i_boundary;
            r_ux   <= DW'(i_b_x) - DW'(i_a_x);
            r_uy   <= DW'(i_b_y) - DW'(i_a_y);
            r_vx   <= DW'(i_c_x) - DW'(i_a_x);
            r_vy   <= DW'(i_c_y) - DW'(i_a_y);
            r_dx[0] <= DW'(i_a_x) - DW'(i_q_x);
            r_dy[0] <= DW'(i_a_y) - DW'(i_q_y);
            r_dx[1] <= DW'(i_b_x) - DW'(i_q_x);
            r_dy[1] <= DW'(i_b_y) - DW'(i_q_y);
            r_dx[2] <= DW'(i_c_x) - DW'(i_q_x);
            r_dy[2] <= DW'(i_c_y) - DW'(i_q_y);
        end
    end

    // stage 2: products
    logic signed [PW1-1:0] r_po1, r_po2;
    logic signed [PW1-1:0] r_sqx [3];
    logic signed [PW1-1:0] r_sqy [3];
    logic signed [PW1-1:0] r_cp1 [3];
    logic signed [PW1-1:0] r_cp2 [3];
    logic                  r_bnd2;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_bnd2 <= r_bnd1;
            r_po1  <= r_ux * r_vy;
            r_po2  <= r_vx * r_uy;
        end
    end

    // stage 3 comb: orientation determinant
    logic signed [SW-1:0] w_orient;
    assign w_orient = SW'(r_po1) - SW'(r_po2);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_flags.boundary <= r_bnd2;
            o_flags.degen    <= (w_orient == '0);
            o_flags.cw       <= w_orient[SW-1];
        end
    end

    // per corner: squares and the minor of the other two corners
    for (genvar k = 0; k < 3; k++) begin : g_term
        localparam int I = (k + 1) % 3;
        localparam int J = (k + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (i_en[1]) begin
                r_sqx[k] <= r_dx[k] * r_dx[k];
                r_sqy[k] <= r_dy[k] * r_dy[k];
                r_cp1[k] <= r_dx[I] * r_dy[J];
                r_cp2[k] <= r_dx[J] * r_dy[I];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[2]) begin
                o_norm[k]  <= SW'(r_sqx[k]) + SW'(r_sqy[k]);
                o_cross[k] <= SW'(r_cp1[k]) - SW'(r_cp2[k]);
            end
        end
    end

endmodule

>>> sv/icp_lift.sv
// ----------------------------------------------------------------------------
// icp_lift
// Stages four to six: each norm times minor as four split partial products,
// recombination of the partials, then the sum of the three terms.
// ----------------------------------------------------------------------------
module icp_lift
    import icp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic [ICP_LIFT_STAGES-1:0]     i_en,
    input  t_icp_flags                     i_flags,
    input  logic signed [2*COORD_BITS+2:0] i_norm  [3],
    input  logic signed [2*COORD_BITS+2:0] i_cross [3],
    output t_icp_flags                     o_flags,
    output logic signed [4*COORD_BITS+7:0] o_det
);

    localparam int SW  = 2 * COORD_BITS + 3;
    localparam int H   = (SW + 1) / 2;
    localparam int HW  = SW - H;
    localparam int LW  = H + 1;
    localparam int PPW = 2 * LW;
    localparam int FW  = 2 * SW;
    localparam int DTW = FW + 2;

    logic signed [PPW-1:0] r_hh [3];
    logic signed [PPW-1:0] r_hl [3];
    logic signed [PPW-1:0] r_lh [3];
    logic signed [PPW-1:0] r_ll [3];
    logic signed [FW-1:0]  r_term [3];
    t_icp_flags            r_flags4, r_flags5;

    // flags follow the arithmetic
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_flags4 <= i_flags;
        end
        if (i_en[1]) begin
            r_flags5 <= r_flags4;
        end
        if (i_en[2]) begin
            o_flags <= r_flags5;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_mul
        logic signed [HW-1:0] w_ah, w_bh;
        logic signed [LW-1:0] w_al, w_bl;

        // high part signed, low part as a non-negative signed value
        assign w_ah = i_norm[k][SW-1:H];
        assign w_bh = i_cross[k][SW-1:H];
        assign w_al = $signed({1'b0, i_norm[k][H-1:0]});
        assign w_bl = $signed({1'b0, i_cross[k][H-1:0]});

        // stage 4: partial products
        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_hh[k] <= w_ah * w_bh;
                r_hl[k] <= w_ah * w_bl;
                r_lh[k] <= w_al * w_bh;
                r_ll[k] <= w_al * w_bl;
            end
        end

        // stage 5: recombine shifted partials
        always_ff @(posedge i_clk) begin
            if (i_en[1]) begin
                r_term[k] <= (FW'(r_hh[k]) <<< (2 * H))
                           + ((FW'(r_hl[k]) + FW'(r_lh[k])) <<< H)
                           + FW'(r_ll[k]);
            end
        end
    end

    // stage 6: incircle determinant
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_det <= DTW'(r_term[0]) + DTW'(r_term[1]) + DTW'(r_term[2]);
        end
    end

endmodule

>>> sv/incircle_predicate_core.sv
// ----------------------------------------------------------------------------
// incircle_predicate_core
// Exact 2-D Delaunay incircle test on a stream of triangle/query words.
// ----------------------------------------------------------------------------
// Input channel (i_s_*): one word per test, tdata holds the eight
// coordinates a_x, a_y, b_x, b_y, c_x, c_y, query_x, query_y as signed
// COORD_BITS-wide fields from the lowest bit up; tuser carries is_boundary.
// Output channel (o_m_*): one word per input word, in order, tdata bit 0 is
// inside_circle, bit 1 degenerate, bit 2 clockwise_order, upper bits zero.
// The datapath is seven register stages: differences, products, sums and
// orientation, split partial products, recombination, determinant sum, and
// the output register. A new word can be taken every cycle unless the
// stages have backed up behind a stalled receiver.
// Each stage advances whenever it is empty or the stage after it moves, so
// when the receiver holds i_m_tready low the bubbles close up first and
// o_s_tready drops only once all seven stages hold words; nothing is lost
// or repeated. Reset clears all stage valid bits; the block is ready in the
// first cycle after reset is released.
// ----------------------------------------------------------------------------
module incircle_predicate_core
    import icp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // slave side
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, query_x, query_y
    input  logic [8*COORD_BITS-1:0]   i_s_tdata,
    // is_boundary
    input  logic                      i_s_tuser,
    // master side
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // inside_circle, degenerate, clockwise_order, zero fill
    output logic [ICP_OUT_W-1:0]      o_m_tdata
);

    localparam int CW  = COORD_BITS;
    localparam int DTW = 4 * COORD_BITS + 8;

    logic [ICP_STAGES-1:0] r_vld;
    logic [ICP_STAGES-1:0] w_en;

    t_icp_flags                 w_front_flags, w_lift_flags;
    logic signed [2*CW+2:0]     w_norm  [3];
    logic signed [2*CW+2:0]     w_cross [3];
    logic signed [DTW-1:0]      w_det;
    logic [2:0]                 r_res, n_res;

    // stage enables: a stage moves when empty or when its successor moves
    always_comb begin
        w_en[ICP_STAGES-1] = !r_vld[ICP_STAGES-1] || i_m_tready;
        for (int k = ICP_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_tready = w_en[0];

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < ICP_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    icp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_en       (w_en[ICP_FRONT_STAGES-1:0]),
        .i_boundary (i_s_tuser),
        .i_a_x      (i_s_tdata[0*CW +: CW]),
        .i_a_y      (i_s_tdata[1*CW +: CW]),
        .i_b_x      (i_s_tdata[2*CW +: CW]),
        .i_b_y      (i_s_tdata[3*CW +: CW]),
        .i_c_x      (i_s_tdata[4*CW +: CW]),
        .i_c_y      (i_s_tdata[5*CW +: CW]),
        .i_q_x      (i_s_tdata[6*CW +: CW]),
        .i_q_y      (i_s_tdata[7*CW +: CW]),
        .o_flags    (w_front_flags),
        .o_norm     (w_norm),
        .o_cross    (w_cross)
    );

    icp_lift #(
        .COORD_BITS (COORD_BITS)
    ) u_lift (
        .i_clk   (i_clk),
        .i_en    (w_en[ICP_FRONT_STAGES +: ICP_LIFT_STAGES]),
        .i_flags (w_front_flags),
        .i_norm  (w_norm),
        .i_cross (w_cross),
        .o_flags (w_lift_flags),
        .o_det   (w_det)
    );

    // output stage: sign test, flipped for clockwise corners; boundary and degenerate words get fixed flags
    always_comb begin
        logic det_neg;
        logic det_pos;
        det_neg = w_det[DTW-1];
        det_pos = !w_det[DTW-1] && (w_det != '0);
        n_res   = 3'b000;
        if (!w_lift_flags.boundary) begin
            if (w_lift_flags.degen) begin
                n_res = 3'b011;
            end else begin
                n_res[0] = w_lift_flags.cw ? det_neg : det_pos;
                n_res[2] = w_lift_flags.cw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ICP_STAGES-1]) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_vld[ICP_STAGES-1];
    assign o_m_tdata  = {(ICP_OUT_W-3)'(0), r_res};

endmodule

>>> test/tb_incircle_predicate_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_incircle_predicate_core
// Self-checking bench for the exact incircle predicate pipeline.
// ----------------------------------------------------------------------------
// Triangle/query words go in on the slave stream and one flag word per input
// comes back on the master stream. Each accepted input word is run through
// an exact 128-bit signed model of the orientation and lifted incircle
// determinants, and the predicted flags queue up in order. Every returned
// word is checked field by field against the oldest prediction. Stimulus
// covers hand-picked corner cases, back-to-back traffic, a long output
// hold-off that fills the pipeline, a full drain pause and a random mix of
// wide, tiny, collinear and cocircular triangles with random handshake gaps.
// ----------------------------------------------------------------------------
module tb_incircle_predicate_core
    import icp_pkg::*;
();

    localparam int COORD_W = 16;

    typedef logic signed [127:0] t_wide;

    // one input word: boundary flag plus eight coordinates
    typedef struct packed {
        logic                      is_boundary;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] q_x;
        logic signed [COORD_W-1:0] q_y;
    } t_tri_word;

    // one result word
    typedef struct packed {
        logic in_circle;
        logic degen;
        logic cw;
    } t_circle_flags;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // a_x, a_y, b_x, b_y, c_x, c_y, query_x, query_y
    logic [8*COORD_W-1:0]   i_s_tdata  = '0;
    // is_boundary
    logic                   i_s_tuser  = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // inside_circle, degenerate, clockwise_order, zero fill
    logic [ICP_OUT_W-1:0]   o_m_tdata;

    t_circle_flags expected_flags[$];
    int            error_count     = 0;
    bit            steady_flow     = 1'b0;
    int            out_hold_cycles = 0;

    incircle_predicate_core #(
        .COORD_BITS (COORD_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // z component of u x v
    function automatic t_wide cross_z(t_wide ux, t_wide uy, t_wide vx, t_wide vy);
        return ux * vy - vx * uy;
    endfunction

    function automatic t_wide sq_len(t_wide x, t_wide y);
        return x * x + y * y;
    endfunction

    // exact incircle decision for one word
    function automatic t_circle_flags predict_incircle(t_tri_word w);
        t_wide ax, ay, bx, by, cx, cy, qx, qy, orient, det;
        t_circle_flags f;
        f = '0;
        if (w.is_boundary)
            return f;
        ax = w.a_x; ay = w.a_y;
        bx = w.b_x; by = w.b_y;
        cx = w.c_x; cy = w.c_y;
        qx = w.q_x; qy = w.q_y;
        orient = cross_z(bx - ax, by - ay, cx - ax, cy - ay);
        if (orient == 0) begin
            f.in_circle = 1'b1;
            f.degen     = 1'b1;
            return f;
        end
        f.cw = (orient < 0);
        // corners relative to the query point
        ax = ax - qx; ay = ay - qy;
        bx = bx - qx; by = by - qy;
        cx = cx - qx; cy = cy - qy;
        det = sq_len(ax, ay) * cross_z(bx, by, cx, cy)
            + sq_len(bx, by) * cross_z(cx, cy, ax, ay)
            + sq_len(cx, cy) * cross_z(ax, ay, bx, by);
        f.in_circle = f.cw ? (det < 0) : (det > 0);
        return f;
    endfunction

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // random triangle, biased toward degenerate and cocircular shapes
    function automatic t_tri_word random_triangle();
        t_tri_word w;
        int pick, x0, y0, x1, y1, dx, dy, k1, k2;
        w    = '0;
        pick = $urandom_range(99);
        if (pick < 35) begin
            w.a_x = 16'($urandom); w.a_y = 16'($urandom);
            w.b_x = 16'($urandom); w.b_y = 16'($urandom);
            w.c_x = 16'($urandom); w.c_y = 16'($urandom);
            w.q_x = 16'($urandom); w.q_y = 16'($urandom);
        end else if (pick < 55) begin
            w.a_x = 16'(span(-6, 6)); w.a_y = 16'(span(-6, 6));
            w.b_x = 16'(span(-6, 6)); w.b_y = 16'(span(-6, 6));
            w.c_x = 16'(span(-6, 6)); w.c_y = 16'(span(-6, 6));
            w.q_x = 16'(span(-6, 6)); w.q_y = 16'(span(-6, 6));
        end else if (pick < 70) begin
            // collinear corners
            x0 = span(-1000, 1000); y0 = span(-1000, 1000);
            dx = span(-20, 20);     dy = span(-20, 20);
            k1 = span(-30, 30);     k2 = span(-30, 30);
            w.a_x = 16'(x0);           w.a_y = 16'(y0);
            w.b_x = 16'(x0 + k1 * dx); w.b_y = 16'(y0 + k1 * dy);
            w.c_x = 16'(x0 + k2 * dx); w.c_y = 16'(y0 + k2 * dy);
            w.q_x = 16'($urandom);     w.q_y = 16'($urandom);
        end else begin
            // rectangle corners: query on the circle, or just off it
            x0 = span(-32000, 32000); y0 = span(-32000, 32000);
            x1 = span(-32000, 32000); y1 = span(-32000, 32000);
            w.a_x = 16'(x0); w.a_y = 16'(y0);
            if ($urandom_range(1) == 0) begin
                w.b_x = 16'(x1); w.b_y = 16'(y0);
                w.c_x = 16'(x1); w.c_y = 16'(y1);
            end else begin
                w.b_x = 16'(x1); w.b_y = 16'(y1);
                w.c_x = 16'(x1); w.c_y = 16'(y0);
            end
            if (pick >= 85) begin
                x0 = x0 + span(-1, 1);
                y1 = y1 + span(-1, 1);
            end
            w.q_x = 16'(x0); w.q_y = 16'(y1);
        end
        w.is_boundary = ($urandom_range(99) < 10);
        return w;
    endfunction

    // offer one word and wait for the handshake; returns just after the edge
    task automatic send_triangle(input t_tri_word w);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 17)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= w.is_boundary;
        i_s_tdata  <= {w.q_y, w.q_x, w.c_y, w.c_x, w.b_y, w.b_x, w.a_y, w.a_x};
        @(negedge i_clk);
        while (!o_s_tready)
            @(negedge i_clk);
        expected_flags.push_back(predict_incircle(w));
        @(posedge i_clk);
    endtask

    task automatic send_coords(input bit bnd, input int ax, input int ay, input int bx,
                               input int by, input int cx, input int cy, input int qx,
                               input int qy);
        t_tri_word w;
        w.is_boundary = bnd;
        w.a_x = 16'(ax); w.a_y = 16'(ay);
        w.b_x = 16'(bx); w.b_y = 16'(by);
        w.c_x = 16'(cx); w.c_y = 16'(cy);
        w.q_x = 16'(qx); w.q_y = 16'(qy);
        send_triangle(w);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        // counter-clockwise: inside, outside, on the circle
        send_coords(0, 0, 0, 4, 0, 0, 4, 1, 1);
        send_coords(0, 0, 0, 4, 0, 0, 4, 10, 10);
        send_coords(0, 0, 0, 4, 0, 0, 4, 4, 4);
        // clockwise: inside, outside, on the circle
        send_coords(0, 0, 0, 0, 4, 4, 0, 1, 1);
        send_coords(0, 0, 0, 0, 4, 4, 0, -5, -5);
        send_coords(0, 0, 0, 0, 4, 4, 0, 4, 4);
        // degenerate: collinear, all coincident, two corners equal
        send_coords(0, 0, 0, 1, 1, 2, 2, 0, 0);
        send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(0, 7, -3, 7, -3, 1, 1, 100, 100);
        // boundary element over a real and a degenerate triangle
        send_coords(1, 0, 0, 4, 0, 0, 4, 1, 1);
        send_coords(1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(1, -1, -1, -1, -1, -1, -1, -1, -1);
        // full-range corners
        send_coords(0, -32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
        send_coords(0, -32768, -32768, 32767, -32768, -32768, 32767, 0, 0);
        send_coords(0, -32768, -32768, -32768, 32767, 32767, -32768, 0, 0);
        send_coords(0, -32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
        send_coords(0, -32768, -32768, -32767, -32768, -32768, -32767, 32767, 32767);
        send_coords(0, -32768, -32768, 0, 0, 32767, 32767, -32768, 32767);
        send_coords(0, 32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768);
        send_coords(1, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
    endtask

    // long stretch with no idling on either side
    task automatic test_back_to_back();
        steady_flow = 1'b1;
        repeat (200) send_triangle(random_triangle());
        steady_flow = 1'b0;
    endtask

    // receiver stalls long enough for the pipeline to fill and back up
    task automatic test_output_hold_off();
        steady_flow     = 1'b1;
        out_hold_cycles = 150;
        repeat (40) send_triangle(random_triangle());
        steady_flow = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_sender_pause();
        repeat (30) send_triangle(random_triangle());
        wait_results_drained();
        repeat (30) send_triangle(random_triangle());
    endtask

    task automatic test_random_mix();
        repeat (1030) send_triangle(random_triangle());
    endtask

    // receiver ready pattern, with the optional long hold-off
    always @(posedge i_clk) begin
        if (out_hold_cycles > 0) begin
            out_hold_cycles <= out_hold_cycles - 1;
            i_m_tready      <= 1'b0;
        end else begin
            i_m_tready <= steady_flow || ($urandom_range(99) >= 30);
        end
    end

    // result checker; a word moves at the edge after a negedge showing both high
    always @(negedge i_clk) begin
        t_circle_flags exp_f;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_flags.size() == 0) begin
                $error("unexpected result word %0h", o_m_tdata);
                error_count++;
            end else begin
                exp_f = expected_flags.pop_front();
                if (o_m_tdata[0] !== exp_f.in_circle) begin
                    $error("inside_circle: expected %0b, got %0b", exp_f.in_circle,
                           o_m_tdata[0]);
                    error_count++;
                end
                if (o_m_tdata[1] !== exp_f.degen) begin
                    $error("degenerate: expected %0b, got %0b", exp_f.degen, o_m_tdata[1]);
                    error_count++;
                end
                if (o_m_tdata[2] !== exp_f.cw) begin
                    $error("clockwise_order: expected %0b, got %0b", exp_f.cw,
                           o_m_tdata[2]);
                    error_count++;
                end
                if (o_m_tdata[ICP_OUT_W-1:3] !== '0) begin
                    $error("zero fill: expected 0, got %0h", o_m_tdata[ICP_OUT_W-1:3]);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_back_to_back();
        test_output_hold_off();
        test_sender_pause();
        test_random_mix();
        wait_results_drained();
        repeat (2 * ICP_STAGES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
